[rtl/pcwh_pkg.sv]
// Shared types and constants for the path component word hash.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pcwh_pkg;

  localparam int WORD_W          = 64;
  localparam int WORD_BYTES      = 8;
  localparam int HASH_W          = 32;
  localparam int LEN_W           = 16;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0]  NUL_BYTE   = 8'h00;
  localparam logic [7:0]  SLASH_BYTE = 8'h2F;
  localparam logic [63:0] GOLDEN64   = 64'h61C8_8646_80B5_83EB;

  // Classified word as it travels from the front end to the mixer.
  typedef struct packed {
    logic        is_end;   // word holds the first terminator byte
    logic [3:0]  add_len;  // bytes counted from this word (0..8)
    logic [63:0] word;     // bytes at and after the terminator cleared
    logic [63:0] salt;
  } pcwh_item_t;

  typedef enum logic [1:0] {
    ST_MIX,   // take words from the queue and mix them
    ST_MUL,   // golden-ratio fold on the shared 32x32 multiplier
    ST_EMIT   // wait for the output register
  } pcwh_state_e;

endpackage

`default_nettype wire

[rtl/pcwh_front.sv]
// Front end: accepts name words, finds the first NUL or '/' byte and
// registers the classified item. Depends on pcwh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcwh_front (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire  [63:0]               name_word_i,
  input  wire  [63:0]               salt_i,
  output logic                      item_valid_o,
  input  wire                       item_ready_i,
  output pcwh_pkg::pcwh_item_t      item_o
);
  import pcwh_pkg::*;

  logic       vld_q;
  pcwh_item_t item_q;
  pcwh_item_t item_d;

  always_comb begin
    logic       seen;
    logic [3:0] idx;
    seen = 1'b0;
    idx  = 4'(WORD_BYTES);
    item_d.word = name_word_i;
    // keep only the bytes ahead of the first terminator
    for (int i = 0; i < WORD_BYTES; i++) begin
      if (!seen && (name_word_i[8*i +: 8] == NUL_BYTE ||
                    name_word_i[8*i +: 8] == SLASH_BYTE)) begin
        seen = 1'b1;
        idx  = 4'(i);
      end
      if (seen) begin
        item_d.word[8*i +: 8] = 8'h00;
      end
    end
    item_d.is_end  = seen;
    item_d.add_len = idx;
    item_d.salt    = salt_i;
  end

  assign in_ready_o   = !vld_q || item_ready_i;
  assign item_valid_o = vld_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

[rtl/pcwh_queue.sv]
// Small FIFO of classified items between the front end and the mixer.
// Depends on pcwh_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

module pcwh_queue #(
  parameter int DEPTH = pcwh_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       push_valid_i,
  output logic                      push_ready_o,
  input  pcwh_pkg::pcwh_item_t      push_item_i,
  output logic                      pop_valid_o,
  input  wire                       pop_ready_i,
  output pcwh_pkg::pcwh_item_t      pop_item_o
);
  import pcwh_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  pcwh_item_t        mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not follow push");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> count_q == $past(count_q) - 1'b1)
    else $error("queue count did not follow pop");

endmodule

`default_nettype wire

[rtl/pcwh_back.sv]
// Back end: per-word mix, length count and the golden-ratio fold on one
// shared 32x32 multiplier, plus the result register. Depends on pcwh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcwh_back #(
  parameter int LENGTH_BITS = pcwh_pkg::LENGTH_BITS_DEF
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       item_valid_i,
  output logic                      item_ready_o,
  input  pcwh_pkg::pcwh_item_t      item_i,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output logic [31:0]               hash_value_o,
  output logic [15:0]               name_length_o
);
  import pcwh_pkg::*;

  localparam logic [LEN_W:0] LenMax = (LENGTH_BITS >= LEN_W) ?
      {1'b0, {LEN_W{1'b1}}} : ((17'd1 << LENGTH_BITS) - 17'd1);

  pcwh_state_e state_q, state_d;
  logic [1:0]  step_q, step_d;
  logic        phase_q, phase_d;     // 0: x*G, 1: (y ^ x*G)*G
  logic        inside_q, inside_d;
  logic [63:0] x_q, x_d, y_q, y_d;
  logic [15:0] cnt_q, cnt_d;
  logic [63:0] op_q, op_d, acc_q, acc_d, prod_q, prod_d;
  logic [31:0] mul_a, mul_b;
  logic        out_valid_q, out_valid_d;
  logic [31:0] hash_q, hash_d;
  logic [15:0] len_q, len_d;
  logic        out_load;

  assign prod_d = mul_a * mul_b;

  always_comb begin
    logic [63:0] xe, ye, xa, ya, xr, yr, acc_sum;
    logic [15:0] ce;
    logic [16:0] sum;

    state_d      = state_q;
    step_d       = step_q;
    phase_d      = phase_q;
    inside_d     = inside_q;
    x_d          = x_q;
    y_d          = y_q;
    cnt_d        = cnt_q;
    op_d         = op_q;
    acc_d        = acc_q;
    item_ready_o = 1'b0;
    out_load     = 1'b0;

    xe  = inside_q ? x_q : '0;
    ye  = inside_q ? y_q : item_i.salt;
    ce  = inside_q ? cnt_q : '0;
    sum = {1'b0, ce} + 17'(item_i.add_len);

    xa = xe ^ item_i.word;
    ya = ye ^ xa;
    xr = {xa[51:0], xa[63:52]};
    yr = {ya[18:0], ya[63:19]};

    acc_sum = acc_q + {prod_q[31:0], 32'h0};

    // operand select: low*low, low*high, high*low (only low 64 bits kept)
    unique case (step_q)
      2'd0:    begin mul_a = op_q[31:0];  mul_b = GOLDEN64[31:0];  end
      2'd1:    begin mul_a = op_q[31:0];  mul_b = GOLDEN64[63:32]; end
      default: begin mul_a = op_q[63:32]; mul_b = GOLDEN64[31:0];  end
    endcase

    unique case (state_q)
      ST_MIX: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          inside_d = 1'b1;
          cnt_d    = (sum >= LenMax) ? LenMax[15:0] : sum[15:0];
          if (item_i.is_end) begin
            x_d      = xa;
            y_d      = ye;
            op_d     = xa;
            inside_d = 1'b0;
            phase_d  = 1'b0;
            step_d   = 2'd0;
            state_d  = ST_MUL;
          end else begin
            x_d = xr + ya;
            y_d = {yr[60:0], 3'b000} + yr;
          end
        end
      end
      ST_MUL: begin
        step_d = step_q + 1'b1;
        unique case (step_q)
          2'd0:    acc_d = acc_q;
          2'd1:    acc_d = prod_q;
          default: acc_d = acc_sum;
        endcase
        if (step_q == 2'd3) begin
          if (!phase_q) begin
            op_d    = y_q ^ acc_sum;
            phase_d = 1'b1;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_MIX;
        end
      end
      default: state_d = ST_MIX;
    endcase

    out_valid_d = out_load || (out_valid_q && !out_ready_i);
    hash_d      = out_load ? acc_q[63:32] : hash_q;
    len_d       = out_load ? cnt_q : len_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_MIX;
      step_q      <= 2'd0;
      phase_q     <= 1'b0;
      inside_q    <= 1'b0;
      cnt_q       <= '0;
      x_q         <= '0;
      y_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      phase_q     <= phase_d;
      inside_q    <= inside_d;
      cnt_q       <= cnt_d;
      x_q         <= x_d;
      y_q         <= y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    hash_q <= hash_d;
    len_q  <= len_d;
  end

  assign out_valid_o   = out_valid_q;
  assign hash_value_o  = hash_q;
  assign name_length_o = len_q;

  a_end_starts_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MIX && item_valid_i && item_i.is_end) |=> state_q == ST_MUL)
    else $error("terminating word did not start the fold");

  a_fold_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL && step_q == 2'd3 && phase_q) |=> state_q == ST_EMIT)
    else $error("fold did not finish after second multiply");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_EMIT)
    else $error("result appeared outside emit");

  a_len_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cnt_q} <= LenMax)
    else $error("byte count above its limit");

  a_no_pop_in_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_MIX) |-> !item_ready_o)
    else $error("queue popped during fold");

endmodule

`default_nettype wire

[rtl/path_component_word_hash.sv]
// Top level of the path component word hash: front end, item queue, mixer.
// Depends on pcwh_pkg, pcwh_front, pcwh_queue and pcwh_back.
//
// Usage: a name component arrives on the input channel (valid/ready) as
// 64-bit little-endian words, first byte in bits 7..0. salt_i is sampled
// only with the first word of each name. Words without a NUL or '/' byte
// are mixed and produce nothing; the word holding the first terminator
// closes the name and yields one transaction on the output channel with
// hash_value_o and name_length_o (saturating byte count).
// The mixer takes one non-terminating word per cycle while it is mixing.
// A terminating word is taken, then folded on the shared 32x32 multiplier
// (two 64-bit products of three partial products, each product
// registered), and then loads the output register; no word is taken
// meanwhile. Words reach the mixer through the front register and queue.
// Reset clears the state; the block then waits for the first word of a
// name. A stalled receiver holds the result in the output register while
// further words keep being mixed; the next result waits until it is taken,
// and the queue then fills and drops in_ready_o.
`timescale 1ns / 1ps
`default_nettype none

module path_component_word_hash #(
  parameter int LENGTH_BITS = pcwh_pkg::LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH = pcwh_pkg::QUEUE_DEPTH_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [63:0] name_word_i,
  input  wire  [63:0] salt_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [31:0] hash_value_o,
  output logic [15:0] name_length_o
);
  import pcwh_pkg::*;

  logic       f_valid, f_ready, q_valid, q_ready;
  pcwh_item_t f_item, q_item;

  pcwh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .name_word_i  (name_word_i),
    .salt_i       (salt_i),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .item_o       (f_item)
  );

  pcwh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  pcwh_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (q_valid),
    .item_ready_o  (q_ready),
    .item_i        (q_item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hash_value_o  (hash_value_o),
    .name_length_o (name_length_o)
  );

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for path_component_word_hash: streams name words,
// predicts each component hash and length, and checks every result in order.
// Depends only on the RTL of the block (rtl/pcwh_pkg.sv and its modules).
`timescale 1ns / 1ps

module testbench;

  localparam int          LEN_BITS    = 16;
  localparam int unsigned LEN_CAP     = (LEN_BITS >= 16) ? 32'hFFFF : (32'd1 << LEN_BITS) - 1;
  localparam logic [63:0] GOLDEN_MULT = 64'h61C8_8646_80B5_83EB;
  localparam logic [7:0]  BYTE_NUL    = 8'h00;
  localparam logic [7:0]  BYTE_SLASH  = 8'h2F;
  localparam int          HOLD_CYCLES = 300;
  localparam int          IDLE_LIMIT  = 4000;
  localparam int          LONG_WORDS  = 40;

  typedef struct packed {
    logic [31:0] hash;
    logic [15:0] len;
  } digest_t;

  // Tracks the hash state of the name in flight and the digests still owed.
  class name_hash_board;
    logic [63:0] acc_x;
    logic [63:0] acc_y;
    int unsigned run_len;
    bit          in_name;
    digest_t     due_digests[$];
    int          errors;
    int          checked;
    int          words;

    function void take_word(logic [63:0] w, logic [63:0] s);
      int          k;
      logic [63:0] fold;
      digest_t     d;
      words++;
      if (!in_name) begin
        acc_x   = '0;
        acc_y   = s;
        run_len = 0;
        in_name = 1'b1;
      end
      k = 8;
      for (int i = 7; i >= 0; i--) begin
        if (w[8*i +: 8] == BYTE_NUL || w[8*i +: 8] == BYTE_SLASH) k = i;
      end
      if (k == 8) begin
        acc_x   = acc_x ^ w;
        acc_y   = acc_y ^ acc_x;
        acc_x   = {acc_x[51:0], acc_x[63:52]};
        acc_x   = acc_x + acc_y;
        acc_y   = {acc_y[18:0], acc_y[63:19]};
        acc_y   = acc_y * 64'd9;
        run_len = (run_len + 8 > LEN_CAP) ? LEN_CAP : run_len + 8;
        return;
      end
      if (k > 0) acc_x = acc_x ^ (w & ((64'd1 << (8 * k)) - 64'd1));
      fold    = acc_y ^ (acc_x * GOLDEN_MULT);
      fold    = fold * GOLDEN_MULT;
      run_len = (run_len + k > LEN_CAP) ? LEN_CAP : run_len + k;
      d.hash  = fold[63:32];
      d.len   = run_len[15:0];
      due_digests.push_back(d);
      in_name = 1'b0;
    endfunction

    function void check_digest(logic [31:0] h, logic [15:0] len);
      digest_t e;
      if (due_digests.size() == 0) begin
        $display("%0t: result with nothing pending: hash %h length %0d", $time, h, len);
        errors++;
        return;
      end
      e = due_digests.pop_front();
      checked++;
      if (e.hash !== h) begin
        $display("%0t: hash_value mismatch: expected %h, actual %h", $time, e.hash, h);
        errors++;
      end
      if (e.len !== len) begin
        $display("%0t: name_length mismatch: expected %0d, actual %0d", $time, e.len, len);
        errors++;
      end
    endfunction

    function int pending();
      return due_digests.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic [63:0] name_word;
  logic [63:0] salt;
  logic        out_ready;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [31:0] hash_value_o;
  logic [15:0] name_length_o;

  name_hash_board board;
  bit             calm;
  bit             hold_req;
  int             idle_cycles;

  path_component_word_hash #(
    .LENGTH_BITS(LEN_BITS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .name_word_i  (name_word),
    .salt_i       (salt),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .hash_value_o (hash_value_o),
    .name_length_o(name_length_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Transaction monitor and watchdog, both on the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) board.take_word(name_word, salt);
      if (out_valid_o && out_ready) board.check_digest(hash_value_o, name_length_o);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog: no transaction for %0d cycles", $time, idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 21);
      end
    end
  end

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == BYTE_NUL || b == BYTE_SLASH);
    return b;
  endfunction

  function automatic logic [63:0] body_word();
    logic [63:0] w;
    for (int i = 0; i < 8; i++) w[8*i +: 8] = plain_byte();
    return w;
  endfunction

  // Terminator at byte pos; bytes past it are arbitrary.
  function automatic logic [63:0] end_word(int pos, bit slash);
    logic [63:0] w;
    w = {$urandom, $urandom};
    for (int i = 0; i < pos; i++) w[8*i +: 8] = plain_byte();
    w[8*pos +: 8] = slash ? BYTE_SLASH : BYTE_NUL;
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic [63:0] w, input logic [63:0] s);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 27) gap = 1;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    name_word <= w;
    salt      <= s;
    in_valid  <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random_name();
    int nbody;
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) nbody = 0;
    else if (r < 70) nbody = $urandom_range(1, 4);
    else if (r < 95) nbody = $urandom_range(5, 12);
    else nbody = $urandom_range(13, 40);
    for (int i = 0; i < nbody; i++) begin
      // some raw words: may close the name early and start another
      if ($urandom_range(0, 99) < 12) send_word({$urandom, $urandom}, {$urandom, $urandom});
      else send_word(body_word(), {$urandom, $urandom});
    end
    send_word(end_word($urandom_range(0, 7), 1'($urandom_range(0, 1))),
              {$urandom, $urandom});
  endtask

  task automatic random_names(int quota);
    int start;
    start = board.words;
    while (board.words - start < quota) send_random_name();
  endtask

  initial begin
    int long_checked;
    board       = new();
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    name_word   = '0;
    salt        = '0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    idle_cycles = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: terminators at every position, extreme bytes and salts.
    send_word(64'h0, '1);
    send_word(64'hFFFF_FFFF_FFFF_FF2F, 64'h0);
    send_word('1, '1);
    send_word(64'h00FF_FFFF_FFFF_FFFF, 64'h0);
    send_word(64'h0101_0101_0101_0101, 64'h0);
    send_word(64'h2E2E_2E2E_2E2E_2E2E, '1);
    send_word(64'h0000_0000_0000_0000, 64'h5555_5555_5555_5555);
    for (int p = 1; p < 8; p++) send_word(end_word(p, 1'(p % 2)), {$urandom, $urandom});
    send_word(64'h2F00_2F00_2F00_0041, 64'hAAAA_AAAA_AAAA_AAAA);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001);
    send_word(64'h8080_8080_8080_8080, 64'h0);
    send_word(64'h7F7F_7F7F_7F7F_7F7F, '1);
    send_word(64'hFF00_FFFF_FFFF_FF00, 64'h0);
    drain();

    // One long name of plain body words.
    send_word(body_word(), {$urandom, $urandom});
    for (int i = 1; i < LONG_WORDS; i++) send_word(body_word(), {$urandom, $urandom});
    send_word(end_word(3, 1'b0), {$urandom, $urandom});
    drain();
    long_checked = board.checked;

    random_names(120);

    // Receiver holds off while single-word names keep coming: queue fills.
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_word(end_word($urandom_range(0, 7), 1'($urandom_range(0, 1))),
                {$urandom, $urandom});
    end
    drain();

    calm = 1'b1;
    random_names(120);
    calm = 1'b0;
    random_names(190);

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Covered %0d name words and %0d hashed components, including a %0d-word name",
             board.words, board.checked, LONG_WORDS + 1);
    $display("(component %0d), a long receiver hold-off and a drain.", long_checked);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
rtl/pcwh_pkg.sv
rtl/pcwh_front.sv
rtl/pcwh_queue.sv
rtl/pcwh_back.sv
rtl/path_component_word_hash.sv
tb/testbench.sv
